// ===== design/plir_pkg.sv =====
package plir_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TAG_W      = 16;
    localparam int LEN_W      = 16;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int INTERVAL_W = 32;
    localparam int LBURST_W   = 16;
    localparam int RBURST_W   = 6;
    localparam int DESC_W     = LEN_W + TAG_W;
    localparam int ADDR_W     = PORT_W + IP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOSS_INTERVAL    = 2'd0,
        REG_LOSS_BURST       = 2'd1,
        REG_REORDER_INTERVAL = 2'd2,
        REG_REORDER_BURST    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_PASS  = 2'd0,
        KIND_DROP  = 2'd1,
        KIND_HOLD  = 2'd2,
        KIND_BURST = 2'd3
    } t_kind;

    typedef struct packed {
        logic consume;
        logic load_pass;
        logic rd_en;
        logic load_drain;
        logic dec_idx;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_kind kind;
        logic  out_free;
        logic  idx_zero;
    } t_sts;

endpackage

// ===== design/plir_ram.sv =====
module plir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/plir_ctrl.sv =====
module plir_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plir_pkg::t_sts i_sts,
    output plir_pkg::t_cmd o_cmd
);

    import plir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sts.in_valid) begin
                    case (i_sts.kind) inside
                        KIND_DROP, KIND_HOLD: begin
                            o_cmd.consume = 1'b1;
                        end
                        KIND_PASS: begin
                            if (i_sts.out_free) begin
                                o_cmd.consume   = 1'b1;
                                o_cmd.load_pass = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.consume = 1'b1;
                            n_state       = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.load_drain = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.dec_idx = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/plir_dp.sv =====
module plir_dp #(
    parameter int REORDER_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [plir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [plir_pkg::TAG_W-1:0]      i_packet_tag,
    input  logic [plir_pkg::LEN_W-1:0]      i_payload_length,
    input  logic [plir_pkg::IP_W-1:0]       i_dest_ip,
    input  logic [plir_pkg::PORT_W-1:0]     i_dest_port,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [plir_pkg::TAG_W-1:0]      o_out_tag,
    output logic [plir_pkg::LEN_W-1:0]      o_out_length,
    output logic [plir_pkg::IP_W-1:0]       o_out_ip,
    output logic [plir_pkg::PORT_W-1:0]     o_out_port,
    output logic                            o_was_reordered,
    output logic                            o_last,
    input  plir_pkg::t_cmd                  i_cmd,
    output plir_pkg::t_sts                  o_sts
);

    import plir_pkg::*;

    localparam int SLOT_W = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
    localparam int FILL_W = $clog2(REORDER_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > RBURST_W) ? FILL_W : RBURST_W;

    logic [INTERVAL_W-1:0] r_loss_int;
    logic [LBURST_W-1:0]   r_loss_burst;
    logic [INTERVAL_W-1:0] r_reord_int;
    logic [RBURST_W-1:0]   r_reord_burst;
    logic [INTERVAL_W-1:0] r_loss_gap;
    logic [LBURST_W-1:0]   r_loss_cnt;
    logic [INTERVAL_W-1:0] r_reord_gap;
    logic [FILL_W-1:0]     r_fill;
    logic [SLOT_W-1:0]     r_idx;

    logic                  r_in_valid;
    logic [TAG_W-1:0]      r_in_tag;
    logic [LEN_W-1:0]      r_in_len;
    logic [IP_W-1:0]       r_in_ip;
    logic [PORT_W-1:0]     r_in_port;

    logic                  r_out_valid;
    logic [TAG_W-1:0]      r_out_tag;
    logic [LEN_W-1:0]      r_out_len;
    logic [IP_W-1:0]       r_out_ip;
    logic [PORT_W-1:0]     r_out_port;
    logic                  r_out_reord;
    logic                  r_out_last;

    logic                  loss_en;
    logic                  loss_hit;
    logic [LBURST_W-1:0]   loss_cnt_inc;
    logic                  reord_en;
    logic                  reord_hit;
    logic [CMP_W-1:0]      burst_ext;
    logic [CMP_W-1:0]      size;
    logic [SLOT_W-1:0]     slot;
    logic [FILL_W-1:0]     fill_new;
    logic                  burst_done;
    t_kind                 kind;
    logic                  wr_en;
    logic [DESC_W-1:0]     rd_desc;
    logic [ADDR_W-1:0]     rd_addr;

    assign loss_en      = (r_loss_int != '0);
    assign loss_hit     = loss_en && (r_loss_gap <= INTERVAL_W'(1));
    assign loss_cnt_inc = r_loss_cnt + LBURST_W'(1);
    assign reord_en     = (r_reord_int != '0);
    assign reord_hit    = reord_en && (r_reord_gap <= INTERVAL_W'(1));
    assign burst_ext    = CMP_W'(r_reord_burst);
    assign size = (burst_ext > CMP_W'(REORDER_DEPTH)) ? CMP_W'(REORDER_DEPTH) : burst_ext;
    assign slot = (r_fill >= FILL_W'(REORDER_DEPTH)) ? SLOT_W'(REORDER_DEPTH - 1)
                                                      : r_fill[SLOT_W-1:0];
    assign fill_new   = FILL_W'(slot) + FILL_W'(1);
    assign burst_done = (CMP_W'(fill_new) >= size);

    always_comb begin
        if (loss_hit) begin
            kind = KIND_DROP;
        end else if (reord_hit) begin
            kind = burst_done ? KIND_BURST : KIND_HOLD;
        end else begin
            kind = KIND_PASS;
        end
    end

    assign wr_en = i_cmd.consume && ((kind == KIND_HOLD) || (kind == KIND_BURST));

    assign o_sts.in_valid = r_in_valid;
    assign o_sts.kind     = kind;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.idx_zero = (r_idx == '0);

    assign o_in_ready = !r_in_valid || i_cmd.consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_int    <= '0;
            r_loss_burst  <= '0;
            r_reord_int   <= '0;
            r_reord_burst <= '0;
            r_loss_gap    <= '0;
            r_loss_cnt    <= '0;
            r_reord_gap   <= '0;
            r_fill        <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (i_cmd.load_pass || i_cmd.load_drain) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_LOSS_INTERVAL: begin
                        r_loss_int <= i_cfg_data;
                        r_loss_gap <= i_cfg_data;
                    end
                    REG_LOSS_BURST: begin
                        r_loss_burst <= i_cfg_data[LBURST_W-1:0];
                    end
                    REG_REORDER_INTERVAL: begin
                        r_reord_int <= i_cfg_data;
                        r_reord_gap <= i_cfg_data;
                    end
                    REG_REORDER_BURST: begin
                        r_reord_burst <= i_cfg_data[RBURST_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.consume) begin
                if (loss_en) begin
                    if (loss_hit) begin
                        if (loss_cnt_inc >= r_loss_burst) begin
                            r_loss_gap <= r_loss_int;
                            r_loss_cnt <= '0;
                        end else begin
                            r_loss_gap <= '0;
                            r_loss_cnt <= loss_cnt_inc;
                        end
                    end else begin
                        r_loss_gap <= r_loss_gap - INTERVAL_W'(1);
                    end
                end
                if (!loss_hit && reord_en) begin
                    if (reord_hit) begin
                        if (burst_done) begin
                            r_reord_gap <= r_reord_int;
                            r_fill      <= '0;
                        end else begin
                            r_reord_gap <= '0;
                            r_fill      <= fill_new;
                        end
                    end else begin
                        r_reord_gap <= r_reord_gap - INTERVAL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_tag  <= i_packet_tag;
            r_in_len  <= i_payload_length;
            r_in_ip   <= i_dest_ip;
            r_in_port <= i_dest_port;
        end

        if (i_cmd.consume && (kind == KIND_BURST)) begin
            r_idx <= slot;
        end else if (i_cmd.dec_idx) begin
            r_idx <= r_idx - SLOT_W'(1);
        end

        if (i_cmd.load_pass) begin
            r_out_tag   <= r_in_tag;
            r_out_len   <= r_in_len;
            r_out_ip    <= r_in_ip;
            r_out_port  <= r_in_port;
            r_out_reord <= 1'b0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.load_drain) begin
            r_out_tag   <= rd_desc[TAG_W-1:0];
            r_out_len   <= rd_desc[DESC_W-1:TAG_W];
            r_out_ip    <= rd_addr[IP_W-1:0];
            r_out_port  <= rd_addr[ADDR_W-1:IP_W];
            r_out_reord <= 1'b1;
            r_out_last  <= (r_idx == '0);
        end
    end

    plir_ram #(
        .WIDTH (DESC_W),
        .DEPTH (REORDER_DEPTH)
    ) u_desc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data ({r_in_len, r_in_tag}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_desc)
    );

    plir_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (REORDER_DEPTH)
    ) u_addr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data ({r_in_port, r_in_ip}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_addr)
    );

    assign o_out_valid     = r_out_valid;
    assign o_out_tag       = r_out_tag;
    assign o_out_length    = r_out_len;
    assign o_out_ip        = r_out_ip;
    assign o_out_port      = r_out_port;
    assign o_was_reordered = r_out_reord;
    assign o_last          = r_out_last;

endmodule

// ===== design/packet_loss_and_reorder_impairment.sv =====
// Periodic packet loss and reorder impairment.
// Input channel (i_in_valid / o_in_ready) carries one packet descriptor per
// transfer; output channel (o_out_valid / i_out_ready) carries the packets to
// send, with o_was_reordered and o_last (last result caused by that input).
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, and the
// user must do so only while idle: the block does not enforce this. Writing
// an interval reloads its gap counter. An accepted descriptor sits in an
// input register while it is passed, dropped or held; passed packets run at
// one per cycle while the receiver takes them, through the input register
// and then the output register. A completed reorder burst drains from the
// held-packet RAM (registered RAM read, then output register); one more input
// is taken into the input register meanwhile and waits for the drain to end.
// Reset (synchronous, active low) clears the configuration registers,
// counters and valids; held-packet RAM contents are not cleared and need no
// clearing pass. When the receiver stalls, the output register holds its
// transfer; input stops once the input register holds a packet to send.
module packet_loss_and_reorder_impairment #(
    parameter int REORDER_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [plir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [plir_pkg::TAG_W-1:0]      i_packet_tag,
    input  logic [plir_pkg::LEN_W-1:0]      i_payload_length,
    input  logic [plir_pkg::IP_W-1:0]       i_dest_ip,
    input  logic [plir_pkg::PORT_W-1:0]     i_dest_port,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [plir_pkg::TAG_W-1:0]      o_out_tag,
    output logic [plir_pkg::LEN_W-1:0]      o_out_length,
    output logic [plir_pkg::IP_W-1:0]       o_out_ip,
    output logic [plir_pkg::PORT_W-1:0]     o_out_port,
    output logic                            o_was_reordered,
    output logic                            o_last
);

    import plir_pkg::*;

    t_cmd cmd;
    t_sts sts;

    plir_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    plir_dp #(
        .REORDER_DEPTH (REORDER_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_packet_tag     (i_packet_tag),
        .i_payload_length (i_payload_length),
        .i_dest_ip        (i_dest_ip),
        .i_dest_port      (i_dest_port),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_tag        (o_out_tag),
        .o_out_length     (o_out_length),
        .o_out_ip         (o_out_ip),
        .o_out_port       (o_out_port),
        .o_was_reordered  (o_was_reordered),
        .o_last           (o_last),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

// ===== design/plir_chk.sv =====
module plir_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [plir_pkg::TAG_W-1:0]  o_out_tag,
    input logic [plir_pkg::LEN_W-1:0]  o_out_length,
    input logic [plir_pkg::IP_W-1:0]   o_out_ip,
    input logic [plir_pkg::PORT_W-1:0] o_out_port,
    input logic                        o_was_reordered,
    input logic                        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_tag) && $stable(o_out_length) && $stable(o_out_ip) &&
            $stable(o_out_port) && $stable(o_was_reordered) && $stable(o_last))
        else $error("output payload changed while stalled");

    a_pass_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_was_reordered |-> o_last)
        else $error("pass-through result without last");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> !o_out_valid || o_was_reordered)
        else $error("reorder burst interrupted by pass-through");

endmodule

bind packet_loss_and_reorder_impairment plir_chk u_plir_chk (.*);

// ===== sim/plir_send_check.sv =====
`timescale 1ns / 100ps

module plir_send_check #(
    parameter int REORDER_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [plir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [plir_pkg::TAG_W-1:0]      i_packet_tag,
    input  logic [plir_pkg::LEN_W-1:0]      i_payload_length,
    input  logic [plir_pkg::IP_W-1:0]       i_dest_ip,
    input  logic [plir_pkg::PORT_W-1:0]     i_dest_port,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [plir_pkg::TAG_W-1:0]      i_out_tag,
    input  logic [plir_pkg::LEN_W-1:0]      i_out_length,
    input  logic [plir_pkg::IP_W-1:0]       i_out_ip,
    input  logic [plir_pkg::PORT_W-1:0]     i_out_port,
    input  logic                            i_was_reordered,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);

    import plir_pkg::*;

    localparam int PRINT_CAP = 30;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } t_pkt;

    typedef struct packed {
        t_pkt pkt;
        logic reordered;
        logic last;
    } t_send;

    logic [INTERVAL_W-1:0] loss_interval;
    logic [INTERVAL_W-1:0] loss_gap;
    logic [LBURST_W-1:0]   loss_burst;
    logic [LBURST_W-1:0]   loss_dropped;
    logic [INTERVAL_W-1:0] reorder_interval;
    logic [INTERVAL_W-1:0] reorder_gap;
    logic [RBURST_W-1:0]   reorder_burst;
    int                    reorder_fill;
    t_pkt                  held_pkts[REORDER_DEPTH];
    t_send                 expected_sends[$];
    int                    mismatches;
    int                    checked;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LOSS_INTERVAL: begin
                loss_interval = data[INTERVAL_W-1:0];
                loss_gap      = data[INTERVAL_W-1:0];
            end
            REG_LOSS_BURST: begin
                loss_burst = data[LBURST_W-1:0];
            end
            REG_REORDER_INTERVAL: begin
                reorder_interval = data[INTERVAL_W-1:0];
                reorder_gap      = data[INTERVAL_W-1:0];
            end
            REG_REORDER_BURST: begin
                reorder_burst = data[RBURST_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic impair_packet(input t_pkt pkt);
        int burst_len;
        int slot;
        if (loss_interval != '0) begin
            if (loss_gap <= 1) begin
                loss_gap     = '0;
                loss_dropped = loss_dropped + 1'b1;
                if (loss_dropped >= loss_burst) begin
                    loss_gap     = loss_interval;
                    loss_dropped = '0;
                end
                return;
            end
            loss_gap = loss_gap - 1'b1;
        end
        if (reorder_interval != '0) begin
            if (reorder_gap <= 1) begin
                reorder_gap = '0;
                burst_len = (int'(reorder_burst) > REORDER_DEPTH) ? REORDER_DEPTH
                                                                   : int'(reorder_burst);
                slot = (reorder_fill >= REORDER_DEPTH) ? REORDER_DEPTH - 1 : reorder_fill;
                held_pkts[slot] = pkt;
                reorder_fill = slot + 1;
                if (reorder_fill >= burst_len) begin
                    for (int i = reorder_fill - 1; i >= 0; i--) begin
                        expected_sends.push_back('{held_pkts[i], 1'b1, i == 0});
                    end
                    reorder_gap  = reorder_interval;
                    reorder_fill = 0;
                end
                return;
            end
            reorder_gap = reorder_gap - 1'b1;
        end
        expected_sends.push_back('{pkt, 1'b0, 1'b1});
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("send %0d: %s is %h, expected %h",
                                      checked, name, got, want));
        end
    endtask

    task automatic check_send();
        t_send want;
        checked++;
        if (expected_sends.size() == 0) begin
            report_mismatch($sformatf("send %0d (tag %h) with no packet pending",
                                      checked, i_out_tag));
            return;
        end
        want = expected_sends.pop_front();
        check_field("out_tag", 32'(i_out_tag), 32'(want.pkt.tag));
        check_field("out_length", 32'(i_out_length), 32'(want.pkt.len));
        check_field("out_ip", i_out_ip, want.pkt.ip);
        check_field("out_port", 32'(i_out_port), 32'(want.pkt.port));
        check_field("was_reordered", 32'(i_was_reordered), 32'(want.reordered));
        check_field("last", 32'(i_last), 32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loss_interval    = '0;
            loss_gap         = '0;
            loss_burst       = '0;
            loss_dropped     = '0;
            reorder_interval = '0;
            reorder_gap      = '0;
            reorder_burst    = '0;
            reorder_fill     = 0;
            expected_sends.delete();
        end else begin
            if (i_cfg_we) begin
                load_register(i_cfg_idx, i_cfg_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_send();
            end
            if (i_in_valid && i_in_ready) begin
                impair_packet('{i_packet_tag, i_payload_length, i_dest_ip, i_dest_port});
            end
        end
        o_pending <= expected_sends.size();
        o_checked <= checked;
    end

endmodule

// ===== sim/tb_packet_loss_and_reorder_impairment.sv =====
`timescale 1ns / 100ps

module tb_packet_loss_and_reorder_impairment;

    import plir_pkg::*;

    localparam int DEPTH        = 32;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [3:0] W_LOSS_IV = 4'(1 << REG_LOSS_INTERVAL);
    localparam logic [3:0] W_LOSS_BS = 4'(1 << REG_LOSS_BURST);
    localparam logic [3:0] W_REOR_IV = 4'(1 << REG_REORDER_INTERVAL);
    localparam logic [3:0] W_REOR_BS = 4'(1 << REG_REORDER_BURST);
    localparam logic [3:0] W_ALL     = W_LOSS_IV | W_LOSS_BS | W_REOR_IV | W_REOR_BS;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    t_reg_idx              cfg_idx    = REG_LOSS_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [TAG_W-1:0]      pkt_tag    = '0;
    logic [LEN_W-1:0]      pkt_len    = '0;
    logic [IP_W-1:0]       pkt_ip     = '0;
    logic [PORT_W-1:0]     pkt_port   = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [TAG_W-1:0]      out_tag;
    logic [LEN_W-1:0]      out_len;
    logic [IP_W-1:0]       out_ip;
    logic [PORT_W-1:0]     out_port;
    logic                  out_reordered;
    logic                  out_last;

    logic steady = 1'b0;
    int   fails;
    int   pending;
    int   checked;
    int   sent;
    int   settings;

    packet_loss_and_reorder_impairment #(
        .REORDER_DEPTH(DEPTH)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_packet_tag    (pkt_tag),
        .i_payload_length(pkt_len),
        .i_dest_ip       (pkt_ip),
        .i_dest_port     (pkt_port),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_tag       (out_tag),
        .o_out_length    (out_len),
        .o_out_ip        (out_ip),
        .o_out_port      (out_port),
        .o_was_reordered (out_reordered),
        .o_last          (out_last)
    );

    plir_send_check #(
        .REORDER_DEPTH(DEPTH)
    ) u_send_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_packet_tag    (pkt_tag),
        .i_payload_length(pkt_len),
        .i_dest_ip       (pkt_ip),
        .i_dest_port     (pkt_port),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_tag       (out_tag),
        .i_out_length    (out_len),
        .i_out_ip        (out_ip),
        .i_out_port      (out_port),
        .i_was_reordered (out_reordered),
        .i_last          (out_last),
        .o_fail_count    (fails),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 22);
    end

    task automatic offer_packet(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len,
                                input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
        while (!steady && $urandom_range(0, 99) < 22) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pkt_tag  <= tag;
        pkt_len  <= len;
        pkt_ip   <= ip;
        pkt_port <= port;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic offer_random();
        offer_packet(16'($urandom), 16'($urandom), $urandom, 16'($urandom));
    endtask

    // wait until every predicted send is out and any dropped or held transfer is done
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [3:0] mask, input logic [31:0] loss_iv,
                                 input logic [31:0] loss_bs, input logic [31:0] reor_iv,
                                 input logic [31:0] reor_bs);
        settle();
        if (mask[REG_LOSS_INTERVAL]) write_reg(REG_LOSS_INTERVAL, loss_iv);
        if (mask[REG_LOSS_BURST]) write_reg(REG_LOSS_BURST, loss_bs);
        if (mask[REG_REORDER_INTERVAL]) write_reg(REG_REORDER_INTERVAL, reor_iv);
        if (mask[REG_REORDER_BURST]) write_reg(REG_REORDER_BURST, reor_bs);
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [31:0] pick_interval(input int hi);
        if ($urandom_range(0, 99) < 25) return '0;
        return $urandom_range(1, hi);
    endfunction

    function automatic logic [31:0] pick_reorder_burst();
        int r;
        logic [5:0] v;
        r = $urandom_range(0, 99);
        if (r < 65) v = 6'($urandom_range(0, 8));
        else if (r < 90) v = 6'($urandom_range(9, 32));
        else v = 6'($urandom_range(33, 63));
        return {26'($urandom), v};
    endfunction

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both stages off: straight pass-through
        offer_packet('0, '0, '0, '0);
        offer_packet('1, '1, '1, '1);
        offer_packet(16'hA5A5, 16'h5A5A, 32'h5A5A_A5A5, 16'hA5A5);

        set_registers(W_LOSS_IV | W_LOSS_BS, 32'd3, 32'd2, '0, '0);
        repeat (5) offer_random();
        // zero burst still drops one
        set_registers(W_LOSS_BS, '0, '0, '0, '0);
        offer_random();

        set_registers(W_ALL, '0, '0, 32'd2, 32'd4);
        repeat (6) offer_random();
        // zero reorder burst still holds and emits one
        set_registers(W_REOR_IV | W_REOR_BS, '0, '0, 32'd1, '0);
        repeat (2) offer_random();

        // burst above depth saturates to a full buffer
        set_registers(W_REOR_BS, '0, '0, '0, {26'($urandom), 6'd63});
        repeat (DEPTH) offer_random();

        // burst lowered while packets are held
        set_registers(W_REOR_BS, '0, '0, '0, 32'd8);
        repeat (3) offer_random();
        set_registers(W_REOR_BS, '0, '0, '0, 32'd2);
        offer_random();

        // reorder stage switched off and back on while holding
        set_registers(W_REOR_BS, '0, '0, '0, 32'd6);
        repeat (2) offer_random();
        set_registers(W_REOR_IV, '0, '0, '0, '0);
        offer_random();
        set_registers(W_REOR_IV, '0, '0, 32'd1, '0);
        offer_random();

        set_registers(W_ALL, '1, 32'h0000_FFFF, '1, '0);
        offer_random();
        set_registers(W_LOSS_IV, 32'd1, '0, '0, '0);
        repeat (2) offer_random();
        // loss stage switched off mid-burst
        set_registers(W_LOSS_IV, '0, '0, '0, '0);
        offer_random();

        for (int p = 0; p < 7; p++) begin
            set_registers((p == 0) ? W_ALL : 4'($urandom_range(1, 15)),
                          pick_interval(12), {16'($urandom), 16'($urandom_range(0, 5))},
                          pick_interval(10), pick_reorder_burst());
            steady = (p == 3 || p == 4);
            repeat (23) offer_random();
        end
        steady = 1'b0;

        settle();
        $display("Sent %0d descriptors under %0d register settings, %0d transfers checked.",
                 sent, settings, checked);
        if (fails == 0) begin
            $display("** packet_loss_and_reorder_impairment: PASSED **");
        end else begin
            $display("** packet_loss_and_reorder_impairment: FAILED **");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timeout with %0d transfers still expected.", pending);
        $display("** packet_loss_and_reorder_impairment: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/plir_pkg.sv
design/plir_ram.sv
design/plir_ctrl.sv
design/plir_dp.sv
design/packet_loss_and_reorder_impairment.sv
design/plir_chk.sv
sim/plir_send_check.sv
sim/tb_packet_loss_and_reorder_impairment.sv
